FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the deque RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dqkr_pkg.sv
// Package: item types, request and status codes, controller to datapath interface
package dqkr_pkg;

	// Request codes
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_REMOVE_KEY = 3'd4;
	localparam logic [2:0] REQ_REMOVE_NEG = 3'd5;
	localparam logic [2:0] REQ_CLEAR      = 3'd6;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] data_value;
		logic [4:0]         removed_count;
		logic [4:0]         fill_level;
		logic [1:0]         status;
	} rsp_item_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_PUSH_FRONT,
		DP_PUSH_BACK,
		DP_POP_EMPTY,
		DP_READ_FRONT,
		DP_READ_BACK,
		DP_POP_FRONT,
		DP_POP_BACK,
		DP_WALK_START,
		DP_WALK,
		DP_WALK_END,
		DP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   by_key;
		logic   load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       empty;
		logic       walk_done;
	} dp_stat_t;

endpackage

FILE: rtl/core/dqkr_dp.sv
// Datapath: entry store, head and fill registers, removal walk and result register
`include "assert_macros.svh"

module dqkr_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dqkr_pkg::req_item_t req,
	input  dqkr_pkg::dp_cmd_t   cmd,
	output dqkr_pkg::dp_stat_t  stat,
	output dqkr_pkg::rsp_item_t rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Circular position of an offset from the head
	function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
		if (s >= (CNT_W + 1)'(DEPTH)) begin
			s = s - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(s);
	endfunction

	logic [WORD_BITS-1:0] store_q [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] val_q;
	logic [2:0]           req_type_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     rd_off_q;
	logic [CNT_W-1:0]     kept_q;
	logic                 proc_v_q;
	logic signed [31:0]   data_q;
	logic [4:0]           removed_q;
	logic [1:0]           status_q;
	dqkr_pkg::rsp_item_t  rsp_q;

	logic                 full;
	logic                 empty;
	logic                 keep;
	logic [IDX_W-1:0]     head_dec;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [WORD_BITS-1:0] wdata;
	logic                 re;
	logic [IDX_W-1:0]     raddr;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
	assign keep     = cmd.by_key ? (rdata_q != val_q) : !rdata_q[WORD_BITS-1];

	// Select the memory port addresses for the current operation
	always_comb begin
		we    = 1'b0;
		waddr = slot(head_q, kept_q);
		wdata = val_q;
		re    = 1'b0;
		raddr = slot(head_q, rd_off_q);
		case (cmd.op)
			dqkr_pkg::DP_PUSH_FRONT: begin
				we    = !full;
				waddr = head_dec;
			end
			dqkr_pkg::DP_PUSH_BACK: begin
				we    = !full;
				waddr = slot(head_q, cnt_q);
			end
			dqkr_pkg::DP_READ_FRONT: begin
				re    = 1'b1;
				raddr = head_q;
			end
			dqkr_pkg::DP_READ_BACK: begin
				re    = 1'b1;
				raddr = slot(head_q, cnt_q - 1'b1);
			end
			dqkr_pkg::DP_WALK: begin
				re    = (rd_off_q != cnt_q);
				we    = proc_v_q && keep;
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

	// Advance head, fill and walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			cnt_q    <= '0;
			rd_off_q <= '0;
			kept_q   <= '0;
			proc_v_q <= 1'b0;
		end else begin
			case (cmd.op)
				dqkr_pkg::DP_PUSH_FRONT: begin
					if (!full) begin
						head_q <= head_dec;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				dqkr_pkg::DP_PUSH_BACK: begin
					if (!full) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				dqkr_pkg::DP_POP_FRONT: begin
					head_q <= slot(head_q, CNT_W'(1));
					cnt_q  <= cnt_q - 1'b1;
				end
				dqkr_pkg::DP_POP_BACK: begin
					cnt_q <= cnt_q - 1'b1;
				end
				dqkr_pkg::DP_WALK_START: begin
					rd_off_q <= '0;
					kept_q   <= '0;
					proc_v_q <= 1'b0;
				end
				dqkr_pkg::DP_WALK: begin
					proc_v_q <= re;
					if (re) begin
						rd_off_q <= rd_off_q + 1'b1;
					end
					if (proc_v_q && keep) begin
						kept_q <= kept_q + 1'b1;
					end
				end
				dqkr_pkg::DP_WALK_END: begin
					cnt_q <= kept_q;
				end
				dqkr_pkg::DP_CLEAR: begin
					head_q <= '0;
					cnt_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the request and build the result fields
	always_ff @(posedge clk) begin
		case (cmd.op)
			dqkr_pkg::DP_LATCH: begin
				req_type_q <= req.req_type;
				val_q      <= WORD_BITS'(req.value);
				data_q     <= '0;
				removed_q  <= '0;
				status_q   <= dqkr_pkg::ST_OK;
			end
			dqkr_pkg::DP_PUSH_FRONT, dqkr_pkg::DP_PUSH_BACK: begin
				if (full) begin
					status_q <= dqkr_pkg::ST_FULL;
				end
			end
			dqkr_pkg::DP_POP_EMPTY: begin
				status_q <= dqkr_pkg::ST_EMPTY;
			end
			dqkr_pkg::DP_POP_FRONT, dqkr_pkg::DP_POP_BACK: begin
				data_q <= 32'(signed'(rdata_q));
			end
			dqkr_pkg::DP_WALK_END: begin
				removed_q <= 5'(cnt_q - kept_q);
			end
			default: begin
			end
		endcase
		if (cmd.load_result) begin
			rsp_q.data_value    <= data_q;
			rsp_q.removed_count <= removed_q;
			rsp_q.fill_level    <= 5'(cnt_q);
			rsp_q.status        <= status_q;
		end
	end

	assign stat.req_type  = req_type_q;
	assign stat.empty     = empty;
	assign stat.walk_done = (rd_off_q == cnt_q) && !proc_v_q;
	assign rsp            = rsp_q;

	`ASSERT_ALWAYS(a_fill_bound, cnt_q <= CNT_W'(DEPTH), "fill exceeds depth")
	`ASSERT_ALWAYS(a_kept_bound, kept_q <= rd_off_q, "kept count passed read offset")
	`ASSERT_NEXT(a_walk_fill, cmd.op == dqkr_pkg::DP_WALK, $stable(cnt_q),
		"fill changed during removal walk")

endmodule

FILE: rtl/core/dqkr_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes
`include "assert_macros.svh"

module dqkr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  dqkr_pkg::dp_stat_t stat,
	output dqkr_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_WALK,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Decode the next step and the datapath operation
	always_comb begin
		state_d         = state_q;
		cmd.op          = dqkr_pkg::DP_NOP;
		cmd.by_key      = (stat.req_type == dqkr_pkg::REQ_REMOVE_KEY);
		cmd.load_result = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = dqkr_pkg::DP_LATCH;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				unique case (stat.req_type) inside
					dqkr_pkg::REQ_PUSH_FRONT: cmd.op = dqkr_pkg::DP_PUSH_FRONT;
					dqkr_pkg::REQ_PUSH_BACK:  cmd.op = dqkr_pkg::DP_PUSH_BACK;
					dqkr_pkg::REQ_POP_FRONT, dqkr_pkg::REQ_POP_BACK: begin
						if (stat.empty) begin
							cmd.op = dqkr_pkg::DP_POP_EMPTY;
						end else begin
							cmd.op  = (stat.req_type == dqkr_pkg::REQ_POP_FRONT) ?
								dqkr_pkg::DP_READ_FRONT : dqkr_pkg::DP_READ_BACK;
							state_d = S_POP;
						end
					end
					dqkr_pkg::REQ_REMOVE_KEY, dqkr_pkg::REQ_REMOVE_NEG: begin
						cmd.op  = dqkr_pkg::DP_WALK_START;
						state_d = S_WALK;
					end
					dqkr_pkg::REQ_CLEAR: cmd.op = dqkr_pkg::DP_CLEAR;
					default: cmd.op = dqkr_pkg::DP_NOP;
				endcase
			end
			S_POP: begin
				cmd.op  = (stat.req_type == dqkr_pkg::REQ_POP_FRONT) ?
					dqkr_pkg::DP_POP_FRONT : dqkr_pkg::DP_POP_BACK;
				state_d = S_FIN;
			end
			S_WALK: begin
				if (stat.walk_done) begin
					cmd.op  = dqkr_pkg::DP_WALK_END;
					state_d = S_FIN;
				end else begin
					cmd.op = dqkr_pkg::DP_WALK;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready,
		"second item accepted while one is in flight")
	`ASSERT_ALWAYS(a_load_free, !cmd.load_result || slot_free,
		"result loaded over an untaken result")
	`ASSERT_NEXT(a_load_valid, cmd.load_result, rsp_valid,
		"loaded result not presented")

endmodule

FILE: rtl/core/deque_with_key_removal.sv
// Top level: bounded double-ended queue with removal by key and of negative entries
//
// Requests enter on req (req_valid/req_ready) and each gives exactly one result
// on rsp (rsp_valid/rsp_ready), in order. One request is worked on at a time.
// Controller states from acceptance to rsp_valid, with the result side free:
//   push, clear, unused code, pop on empty: S_IDLE, S_EXEC, S_FIN
//   pop: S_IDLE, S_EXEC, S_POP, S_FIN (one registered read of the entry store)
//   remove key / remove negatives: S_IDLE, S_EXEC, S_WALK, S_FIN, with the
//   walk over the store reading one entry and writing back one surviving
//   entry per cycle
// req_ready rises again in the same cycle as rsp_valid, so with the result side
// free a new request can be accepted from that cycle on.
// The result sits in an output register: a stalled receiver holds rsp, and the
// next request is accepted meanwhile but finishes only once that result is taken.
// Reset empties the queue (fill 0, head 0) at once; no clearing pass is needed,
// as only entries inside the fill are ever read.

module deque_with_key_removal #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  dqkr_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output dqkr_pkg::rsp_item_t rsp
);

	dqkr_pkg::dp_cmd_t  cmd;
	dqkr_pkg::dp_stat_t stat;

	dqkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dqkr_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
